@@ hw/rtl/dcba_pkg.sv @@
package dcba_pkg;

	// Widths fixed by the item and register formats
	localparam int CUR_W      = 16;
	localparam int STAMP_W    = 32;
	localparam int CFG_W      = 32;
	localparam int RUN_W      = 8;
	localparam int REG_IDX_W  = 3;

	// Timestamp width used for last-raise time and elapsed-time math
	localparam int TIME_BITS_DEF = 32;

	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_HIGH = 2'd1,
		KIND_LOW  = 2'd2
	} kind_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DEBOUNCE = 3'd0,
		REG_COOLDOWN = 3'd1,
		REG_HIGH_THR = 3'd2,
		REG_LOW_THR  = 3'd3,
		REG_NOISE    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic        [RUN_W-1:0] debounce_count;
		logic        [CFG_W-1:0] cooldown_ms;
		logic signed [CUR_W-1:0] high_threshold;
		logic signed [CUR_W-1:0] low_threshold;
		logic signed [CUR_W-1:0] noise_floor;
	} cfg_t;

	localparam logic        [RUN_W-1:0] DEBOUNCE_RST = 8'd3;
	localparam logic        [CFG_W-1:0] COOLDOWN_RST = 32'd60000;
	localparam logic signed [CUR_W-1:0] HIGH_THR_RST = 16'sd10000;
	localparam logic signed [CUR_W-1:0] LOW_THR_RST  = 16'sd1000;
	localparam logic signed [CUR_W-1:0] NOISE_RST    = 16'sd150;

endpackage

@@ hw/rtl/dcba_in_if.sv @@
interface dcba_in_if
	import dcba_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic signed [CUR_W-1:0] current_ma;
	logic [STAMP_W-1:0]      time_ms;

	modport source (output valid, req_type, current_ma, time_ms, input ready);
	modport sink   (input valid, req_type, current_ma, time_ms, output ready);
endinterface

@@ hw/rtl/dcba_out_if.sv @@
interface dcba_out_if
	import dcba_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [1:0] alert_kind;
	logic       alert_active;
	logic       alert_raised;

	modport source (output valid, alert_kind, alert_active, alert_raised, input ready);
	modport sink   (input valid, alert_kind, alert_active, alert_raised, output ready);
endinterface

@@ hw/rtl/dcba_cfg_regs.sv @@
module dcba_cfg_regs
	import dcba_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_count <= DEBOUNCE_RST;
			cfg_q.cooldown_ms    <= COOLDOWN_RST;
			cfg_q.high_threshold <= HIGH_THR_RST;
			cfg_q.low_threshold  <= LOW_THR_RST;
			cfg_q.noise_floor    <= NOISE_RST;
		end else if (cfg_we) begin
			// drop writes beyond the register list
			unique case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_count <= cfg_wdata[RUN_W-1:0];
				REG_COOLDOWN: cfg_q.cooldown_ms    <= cfg_wdata;
				REG_HIGH_THR: cfg_q.high_threshold <= cfg_wdata[CUR_W-1:0];
				REG_LOW_THR:  cfg_q.low_threshold  <= cfg_wdata[CUR_W-1:0];
				REG_NOISE:    cfg_q.noise_floor    <= cfg_wdata[CUR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/debounced_current_band_alarm_core.sv @@
// Channel   Dir  Payload                                  Handshake
// in_ch     in   req_type, current_ma, time_ms            valid/ready
// out_ch    out  alert_kind, alert_active, alert_raised   valid/ready
// cfg       in   cfg_we, cfg_index, cfg_wdata             write on cfg_we
//
// One item per cycle sustained while out_ch is ready; an accepted item is held in the
// input register, then in the result register, from which it is offered on out_ch.
// The alert state update sits between the input register and the result
// register: one signed compare set, an 8-bit counter and a TIME_BITS subtract
// with compare, all combinational.
// Reset (arst_n low) clears all control state and loads register defaults.
// A stalled out_ch holds its item; in_ch keeps taking items until the input
// register is also full.
module debounced_current_band_alarm_core
	import dcba_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	dcba_in_if.sink              in_ch,
	dcba_out_if.source           out_ch
);

	// Elapsed time and cooldown are compared at the wider of the two widths
	localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

	cfg_t cfg;

	dcba_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// ---------------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------------
	logic                    valid_s1;
	logic                    clear_s1;
	logic signed [CUR_W-1:0] cur_s1;
	logic [TIME_BITS-1:0]    now_s1;
	logic [TIME_BITS-1:0]    now_in;

	logic out_valid_q;
	logic adv;      // item in the input register moves into the result register
	logic take_in;

	// Mask the stamp to TIME_BITS, or zero-extend it when TIME_BITS is wider
	generate
		if (TIME_BITS >= STAMP_W) begin : g_stamp_ext
			assign now_in = TIME_BITS'(in_ch.time_ms);
		end else begin : g_stamp_mask
			assign now_in = in_ch.time_ms[TIME_BITS-1:0];
		end
	endgenerate

	assign adv     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign take_in = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			clear_s1 <= in_ch.req_type;
			cur_s1   <= in_ch.current_ma;
			now_s1   <= now_in;
		end
	end

	// ---------------------------------------------------------------------
	// Alert state
	// ---------------------------------------------------------------------
	kind_t                present_q;
	kind_t                cand_q;
	logic [RUN_W-1:0]     run_q;
	logic [TIME_BITS-1:0] last_raise_q;
	logic                 raise_valid_q;

	kind_t                cls;
	logic [RUN_W-1:0]     run_next;
	logic [TIME_BITS-1:0] since;
	logic                 cool_ok;
	logic                 raise;

	// Classify: HIGH wins over LOW; LOW needs to sit strictly above the floor
	always_comb begin
		cls = KIND_NONE;
		if (cur_s1 > cfg.high_threshold) begin
			cls = KIND_HIGH;
		end else if (cur_s1 > cfg.noise_floor && cur_s1 < cfg.low_threshold) begin
			cls = KIND_LOW;
		end
	end

	// Extend the run on a repeat of the candidate, saturating; restart otherwise
	always_comb begin
		if (cls == cand_q) begin
			run_next = (run_q == RUN_MAX) ? run_q : run_q + RUN_W'(1);
		end else begin
			run_next = RUN_W'(1);
		end
	end

	// Wrapping elapsed time; a block that never raised ignores the cooldown
	assign since   = now_s1 - last_raise_q;
	assign cool_ok = !raise_valid_q || (CMP_W'(since) > CMP_W'(cfg.cooldown_ms));

	assign raise = !clear_s1 && (cls != KIND_NONE) && (run_next >= cfg.debounce_count)
		&& (present_q != cls) && cool_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q     <= KIND_NONE;
			cand_q        <= KIND_NONE;
			run_q         <= '0;
			last_raise_q  <= '0;
			raise_valid_q <= 1'b0;
		end else if (adv) begin
			if (clear_s1 || cls == KIND_NONE) begin
				// Clear item or normal sample: drop alert and run, keep raise time
				present_q <= KIND_NONE;
				cand_q    <= KIND_NONE;
				run_q     <= '0;
			end else begin
				cand_q <= cls;
				run_q  <= run_next;
				if (raise) begin
					present_q     <= cls;
					last_raise_q  <= now_s1;
					raise_valid_q <= 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------------
	kind_t kind_next;
	kind_t kind_q;
	logic  raised_q;

	always_comb begin
		if (clear_s1 || cls == KIND_NONE) begin
			kind_next = KIND_NONE;
		end else if (raise) begin
			kind_next = cls;
		end else begin
			kind_next = present_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_q   <= kind_next;
			raised_q <= raise;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.alert_kind   = kind_q;
	assign out_ch.alert_active = (kind_q != KIND_NONE);
	assign out_ch.alert_raised = raised_q;

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	a_run_needs_cand: assert property (@(posedge clk) disable iff (!arst_n)
		(cand_q == KIND_NONE) |-> (run_q == '0))
		else $error("run count nonzero without a candidate");

	a_alert_implies_raised: assert property (@(posedge clk) disable iff (!arst_n)
		(present_q != KIND_NONE) |-> raise_valid_q)
		else $error("alert present but no raise recorded");

	a_raise_sets_alert: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && raise) |=> (present_q != KIND_NONE && last_raise_q == $past(now_s1)))
		else $error("raise did not update alert state");

	a_raised_is_active: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.alert_raised) |-> out_ch.alert_active)
		else $error("raised result without active alert");

endmodule

@@ sim/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dcba_pkg::*;

	// Stop the run here if the results stop flowing
	localparam int CYCLE_LIMIT = 200000;

	// One reading or clear item as the sender presents it
	typedef struct {
		logic                    clr;
		logic signed [CUR_W-1:0] cur;
		logic [STAMP_W-1:0]      stamp;
	} reading_t;

	// Alarm status that one item must produce
	typedef struct {
		kind_t kind;
		logic  active;
		logic  raised;
	} alert_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	dcba_in_if  in_ch();
	dcba_out_if out_ch();

	debounced_current_band_alarm_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always #5 clk = ~clk;

	// Items waiting to be offered, and alarm states still owed by the block
	reading_t readings_q[$];
	alert_t   alerts_due[$];

	// Our copy of the register file, kept in step with every write
	logic [RUN_W-1:0]        need_run = DEBOUNCE_RST;
	logic [CFG_W-1:0]        cool_ms  = COOLDOWN_RST;
	logic signed [CUR_W-1:0] hi_ma    = HIGH_THR_RST;
	logic signed [CUR_W-1:0] lo_ma    = LOW_THR_RST;
	logic signed [CUR_W-1:0] floor_ma = NOISE_RST;

	// Our copy of the alarm state
	kind_t              alarm_kind  = KIND_NONE;
	kind_t              cand_kind   = KIND_NONE;
	logic [RUN_W-1:0]   run_len     = '0;
	logic [STAMP_W-1:0] raise_stamp = '0;
	logic               raised_once = 1'b0;

	int                 errors = 0;
	int                 cycles = 0;
	int                 posted = 0;
	logic [STAMP_W-1:0] clock_ms = '0;

	// Sender pacing: burst length, gap after it, and the next point to drain
	int   burst_left = 8;
	int   gap_left   = 0;
	int   fed        = 0;
	int   drain_at   = 40;
	logic draining   = 1'b0;
	logic in_taken   = 1'b0;

	// Receiver pacing
	int rdy_mode = 0;
	int rdy_left = 0;

	// Apply one accepted item to the alarm copy and queue the status it must yield.
	task automatic advance_alarm(input logic clr, input logic signed [CUR_W-1:0] cur,
	                             input logic [STAMP_W-1:0] stamp);
		kind_t              cls;
		logic               rose;
		logic [STAMP_W-1:0] since;
		alert_t             want;
		rose = 1'b0;
		if (clr) begin
			// Clear keeps the last raise time and the raised-once flag
			alarm_kind = KIND_NONE;
			cand_kind  = KIND_NONE;
			run_len    = '0;
		end else begin
			cls = KIND_NONE;
			if (cur > hi_ma)
				cls = KIND_HIGH;
			else if (cur > floor_ma && cur < lo_ma)
				cls = KIND_LOW;
			if (cls != KIND_NONE) begin
				// Count the run against the candidate, saturating at the top
				if (cls == cand_kind) begin
					if (run_len != RUN_MAX)
						run_len++;
				end else begin
					cand_kind = cls;
					run_len   = RUN_W'(1);
				end
				if (run_len >= need_run && alarm_kind != cls) begin
					// Elapsed time wraps with the timestamp
					since = stamp - raise_stamp;
					if (!raised_once || since > cool_ms) begin
						alarm_kind  = cls;
						raise_stamp = stamp;
						raised_once = 1'b1;
						rose        = 1'b1;
					end
				end
			end else begin
				// A normal sample drops the alarm and the debounce run
				alarm_kind = KIND_NONE;
				cand_kind  = KIND_NONE;
				run_len    = '0;
			end
		end
		want.kind   = alarm_kind;
		want.active = (alarm_kind != KIND_NONE);
		want.raised = rose;
		alerts_due.push_back(want);
	endtask

	task automatic post(input logic clr, input logic signed [CUR_W-1:0] cur,
	                    input logic [STAMP_W-1:0] stamp);
		reading_t r;
		r.clr   = clr;
		r.cur   = cur;
		r.stamp = stamp;
		readings_q.push_back(r);
		posted++;
	endtask

	// Advance the millisecond clock: small steps, steps right at the cooldown,
	// wide jumps and jumps to just below the wrap point.
	function automatic logic [STAMP_W-1:0] next_stamp(input int small_pct);
		if (int'($urandom_range(0, 99)) < small_pct) begin
			clock_ms += $urandom_range(0, 20);
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2: clock_ms += $urandom_range(0, 20);
				3, 4:    clock_ms += cool_ms + $urandom_range(0, 4) - 2;
				5, 6:    clock_ms += $urandom_range(0, cool_ms);
				7:       clock_ms = $urandom;
				8:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 50);
				default: ;
			endcase
		end
		return clock_ms;
	endfunction

	// Pick a current in [lo, hi], favoring both ends; random if the range is empty.
	function automatic logic signed [CUR_W-1:0] pick_ma(input int lo, input int hi);
		if (lo > hi)
			return CUR_W'($urandom);
		case ($urandom_range(0, 7))
			0:       return CUR_W'(lo);
			1:       return CUR_W'(hi);
			default: return CUR_W'(lo + int'($urandom_range(0, hi - lo)));
		endcase
	endfunction

	function automatic logic signed [CUR_W-1:0] ma_for(input kind_t k);
		int hi;
		int lo;
		int fl;
		hi = int'(hi_ma);
		lo = int'(lo_ma);
		fl = int'(floor_ma);
		case (k)
			KIND_HIGH: return pick_ma(hi + 1, 32767);
			KIND_LOW:  return pick_ma(fl + 1, lo - 1);
			default: begin
				if ($urandom_range(0, 1))
					return pick_ma(-32768, fl);
				return pick_ma(lo, hi);
			end
		endcase
	endfunction

	// Mostly debounce runs of one class with random content; some clears and noise.
	task automatic queue_episode();
		int    roll;
		int    len;
		kind_t k;
		roll = $urandom_range(0, 19);
		if (roll < 2) begin
			post(1'b1, CUR_W'($urandom), $urandom);
		end else if (roll < 5) begin
			len = $urandom_range(1, 4);
			repeat (len) post(1'b0, CUR_W'($urandom), next_stamp(0));
		end else begin
			case ($urandom_range(0, 4))
				0, 1:    k = KIND_HIGH;
				2, 3:    k = KIND_LOW;
				default: k = KIND_NONE;
			endcase
			// Runs around the debounce length; long debounce runs are capped
			len = $urandom_range(1, (need_run > 37) ? 40 : need_run + 3);
			for (int i = 0; i < len; i++)
				post(1'b0, ma_for(k), next_stamp((i == 0) ? 0 : 80));
		end
	endtask

	task automatic random_phase(input int quota);
		int target;
		target = posted + quota;
		while (posted < target)
			queue_episode();
	endtask

	// Wait until every item is in and every status is out, then let the pipe empty.
	task automatic settle();
		while (readings_q.size() != 0 || alerts_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_DEBOUNCE: need_run = val[RUN_W-1:0];
			REG_COOLDOWN: cool_ms  = val;
			REG_HIGH_THR: hi_ma    = val[CUR_W-1:0];
			REG_LOW_THR:  lo_ma    = val[CUR_W-1:0];
			REG_NOISE:    floor_ma = val[CUR_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Write all five registers; junk in the unused upper bits must be dropped.
	task automatic program_regs(input int deb, input logic [CFG_W-1:0] cool,
	                            input int hi, input int lo, input int fl);
		write_reg(REG_DEBOUNCE, ($urandom & 32'hFFFF_FF00) | (deb & 32'hFF));
		write_reg(REG_COOLDOWN, cool);
		write_reg(REG_HIGH_THR, ($urandom & 32'hFFFF_0000) | (hi & 32'hFFFF));
		write_reg(REG_LOW_THR,  ($urandom & 32'hFFFF_0000) | (lo & 32'hFFFF));
		write_reg(REG_NOISE,    ($urandom & 32'hFFFF_0000) | (fl & 32'hFFFF));
	endtask

	// Driver: hold an offered item until taken, otherwise pace the next one.
	always @(negedge clk) begin
		reading_t nxt;
		logic     go;
		if (arst_n && !(in_ch.valid && !in_taken)) begin
			go = 1'b0;
			if (draining && alerts_due.size() == 0)
				draining = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (!draining && readings_q.size() != 0) begin
				go  = 1'b1;
				nxt = readings_q[0];
				fed++;
				// Every so often, drain the block completely before going on
				if (fed == drain_at) begin
					draining = 1'b1;
					drain_at += $urandom_range(60, 160);
				end
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end
			end
			in_ch.valid <= go;
			if (go) begin
				in_ch.req_type   <= nxt.clr;
				in_ch.current_ma <= nxt.cur;
				in_ch.time_ms    <= nxt.stamp;
			end
		end
		in_taken <= 1'b0;
	end

	// Receiver stalls: always ready, coin flips, mostly stalled, or a fixed pattern.
	always @(negedge clk) begin
		if (rdy_left == 0) begin
			rdy_mode = $urandom_range(0, 3);
			rdy_left = $urandom_range(20, 150);
		end
		rdy_left--;
		case (rdy_mode)
			0:       out_ch.ready <= 1'b1;
			1:       out_ch.ready <= $urandom_range(0, 1);
			2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
			default: out_ch.ready <= (rdy_left % 5) < 3;
		endcase
	end

	// Monitor: check each status against the oldest one owed, predict each item taken.
	always @(posedge clk) begin
		alert_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (alerts_due.size() == 0) begin
					$error("alert_kind: expected nothing, got %0d", out_ch.alert_kind);
					errors++;
				end else begin
					want = alerts_due.pop_front();
					if (out_ch.alert_kind !== want.kind) begin
						$error("alert_kind: expected %0d, got %0d", want.kind,
						       out_ch.alert_kind);
						errors++;
					end
					if (out_ch.alert_active !== want.active) begin
						$error("alert_active: expected %0d, got %0d", want.active,
						       out_ch.alert_active);
						errors++;
					end
					if (out_ch.alert_raised !== want.raised) begin
						$error("alert_raised: expected %0d, got %0d", want.raised,
						       out_ch.alert_raised);
						errors++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				advance_alarm(in_ch.req_type, in_ch.current_ma, in_ch.time_ms);
				void'(readings_q.pop_front());
				in_taken <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("debounced_current_band_alarm_core verification failed");
			$finish;
		end
	end

	initial begin
		cfg_we           = 1'b0;
		cfg_index        = REG_DEBOUNCE;
		cfg_wdata        = '0;
		in_ch.valid      = 1'b0;
		in_ch.req_type   = 1'b0;
		in_ch.current_ma = '0;
		in_ch.time_ms    = '0;
		out_ch.ready     = 1'b0;
		arst_n           = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset settings.
		// Never raised: a raise at timestamp zero is real and starts the cooldown.
		post(1'b0, 32767, 0);
		post(1'b0, 10001, 0);
		post(1'b0, 20000, 0);
		// LOW debounced but blocked by the cooldown, then allowed once it passes
		post(1'b0, 151, 5);
		post(1'b0, 999, 10);
		post(1'b0, 500, 20);
		post(1'b0, 600, 60001);
		// Clear ignores current and time
		post(1'b1, -32768, 32'hFFFF_FFFF);
		// Band edges are all normal
		post(1'b0, 150, 60002);
		post(1'b0, 1000, 60003);
		post(1'b0, 10000, 60004);
		post(1'b0, -32768, 60005);
		// Raise just below the wrap, then check elapsed time across the wrap
		post(1'b0, 15000, 32'hFFFF_FFF0);
		post(1'b0, 15001, 32'hFFFF_FFF0);
		post(1'b0, 15002, 32'hFFFF_FFF0);
		post(1'b0, 300, 5);
		post(1'b0, 301, 6);
		post(1'b0, 302, 7);
		post(1'b0, 303, 60020);
		post(1'b1, 32767, 0);
		// Debounce restarts after a clear
		post(1'b0, 12000, 120037);
		post(1'b0, 32767, 120037);
		post(1'b0, 12001, 120037);
		// Elapsed exactly equal to the cooldown does not raise; one more ms does
		post(1'b0, 400, 180037);
		post(1'b0, 401, 180037);
		post(1'b0, 402, 180037);
		post(1'b0, 403, 180038);
		clock_ms = 180038;
		settle();

		// Zero debounce and zero cooldown: every non-normal sample may raise
		program_regs(0, 0, 2000, 500, -200);
		random_phase(45);
		settle();

		program_regs(1, 100, 0, -300, -1000);
		random_phase(45);
		settle();

		// Run saturation: raise LOW quickly, then hold a HIGH run well past 255
		// while the cooldown keeps it back, so the raise lands after the top.
		program_regs(1, 2800, 8000, 3000, 100);
		post(1'b1, 0, 0);
		clock_ms += 32'h4000_0000;
		post(1'b0, 1500, clock_ms);
		settle();
		program_regs(255, 2800, 8000, 3000, 100);
		repeat (320) post(1'b0, ma_for(KIND_HIGH), next_stamp(100));
		random_phase(20);
		settle();

		// Longest cooldown, thresholds at the bottom: almost all HIGH, no LOW
		program_regs(4, 32'hFFFF_FFFF, -32768, -32768, 32767);
		random_phase(45);
		settle();

		// Low threshold below the noise floor: no sample can be LOW
		program_regs(2, 1000, 5000, 100, 300);
		random_phase(45);
		settle();

		// Nothing can be HIGH; the LOW band spans almost the whole range
		program_regs(255, 0, 32767, 32767, -32768);
		random_phase(45);
		settle();

		program_regs($urandom, $urandom, $urandom, $urandom, $urandom);
		random_phase(45);
		settle();

		program_regs($urandom_range(0, 8), $urandom_range(0, 3000),
		             $urandom_range(0, 3000), int'($urandom_range(0, 600)) - 300,
		             int'($urandom_range(0, 400)) - 400);
		random_phase(45);
		settle();

		if (errors == 0)
			$display("debounced_current_band_alarm_core verification clean");
		else
			$display("debounced_current_band_alarm_core verification failed");
		$finish;
	end

endmodule
